[design/fixed_point_fft_spectrum_magnitude_unit_assert.svh]
// ----------------------------------------------------------------------------
// Spectrum magnitude unit assertion macros
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_FFT_SPECTRUM_MAGNITUDE_UNIT_ASSERT_SVH
`define FIXED_POINT_FFT_SPECTRUM_MAGNITUDE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFSM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffsm: assertion failed");
`define FFSM_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ffsm: forbidden condition seen");
`else
`define FFSM_ASSERT(lbl, clk, rst, prop)
`define FFSM_NEVER(lbl, clk, rst, cond)
`endif
`endif

[design/ffsm_pkg.sv]
// ----------------------------------------------------------------------------
// ffsm_pkg
// Types, constants and the twiddle table of the spectrum magnitude unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsm_pkg;

   localparam int MAX_LOG2_POINTS_DEF = 11;
   localparam int LOG2_W              = 4;
   localparam int LOG2_RESET          = 11;
   localparam int SAMPLE_SHIFT        = 12;
   localparam int ROT_SHIFT           = 29;
   localparam logic [15:0] MAG_SAT   = 16'hFFFF;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic [10:0] bin_index;
      logic [15:0] magnitude;
      logic        last;
      logic        ready_res;
   } rsp_type;

   typedef struct packed {
      logic signed [28:0] c;
      logic signed [28:0] s;
   } twiddle_type;

   // eighth of a turn (0 to pi/4), {cos, sin} scaled by 2^28
   localparam logic [55:0] QUARTER_ROM [0:256] = '{
      {28'd268435455, 28'd0}, {28'd268434192, 28'd823548}, {28'd268430402, 28'd1647088},
      {28'd268424086, 28'd2470614}, {28'd268415243, 28'd3294115}, {28'd268403873, 28'd4117586},
      {28'd268389978, 28'd4941018}, {28'd268373556, 28'd5764404}, {28'd268354608, 28'd6587735},
      {28'd268333134, 28'd7411005}, {28'd268309134, 28'd8234204}, {28'd268282610, 28'd9057326},
      {28'd268253559, 28'd9880363}, {28'd268221985, 28'd10703307}, {28'd268187885, 28'd11526150},
      {28'd268151261, 28'd12348885}, {28'd268112113, 28'd13171503}, {28'd268070442, 28'd13993997},
      {28'd268026247, 28'd14816360}, {28'd267979530, 28'd15638583}, {28'd267930290, 28'd16460659},
      {28'd267878529, 28'd17282580}, {28'd267824246, 28'd18104339}, {28'd267767442, 28'd18925927},
      {28'd267708118, 28'd19747337}, {28'd267646274, 28'd20568561}, {28'd267581911, 28'd21389591},
      {28'd267515029, 28'd22210420}, {28'd267445630, 28'd23031040}, {28'd267373713, 28'd23851443},
      {28'd267299279, 28'd24671622}, {28'd267222330, 28'd25491569}, {28'd267142865, 28'd26311275},
      {28'd267060886, 28'd27130734}, {28'd266976394, 28'd27949938}, {28'd266889388, 28'd28768878},
      {28'd266799870, 28'd29587548}, {28'd266707841, 28'd30405939}, {28'd266613302, 28'd31224044},
      {28'd266516253, 28'd32041855}, {28'd266416696, 28'd32859365}, {28'd266314631, 28'd33676565},
      {28'd266210059, 28'd34493448}, {28'd266102982, 28'd35310007}, {28'd265993400, 28'd36126233},
      {28'd265881315, 28'd36942120}, {28'd265766727, 28'd37757658}, {28'd265649637, 28'd38572841},
      {28'd265530047, 28'd39387661}, {28'd265407958, 28'd40202111}, {28'd265283370, 28'd41016182},
      {28'd265156286, 28'd41829866}, {28'd265026706, 28'd42643158}, {28'd264894631, 28'd43456047},
      {28'd264760063, 28'd44268528}, {28'd264623003, 28'd45080592}, {28'd264483453, 28'd45892232},
      {28'd264341413, 28'd46703440}, {28'd264196884, 28'd47514208}, {28'd264049870, 28'd48324529},
      {28'd263900369, 28'd49134395}, {28'd263748385, 28'd49943799}, {28'd263593918, 28'd50752733},
      {28'd263436971, 28'd51561188}, {28'd263277543, 28'd52369159}, {28'd263115638, 28'd53176637},
      {28'd262951256, 28'd53983614}, {28'd262784399, 28'd54790083}, {28'd262615069, 28'd55596036},
      {28'd262443267, 28'd56401466}, {28'd262268994, 28'd57206365}, {28'd262092254, 28'd58010726},
      {28'd261913046, 28'd58814541}, {28'd261731373, 28'd59617802}, {28'd261547236, 28'd60420502},
      {28'd261360638, 28'd61222633}, {28'd261171579, 28'd62024188}, {28'd260980063, 28'd62825159},
      {28'd260786089, 28'd63625539}, {28'd260589662, 28'd64425320}, {28'd260390781, 28'd65224495},
      {28'd260189450, 28'd66023056}, {28'd259985670, 28'd66820995}, {28'd259779442, 28'd67618305},
      {28'd259570769, 28'd68414979}, {28'd259359654, 28'd69211009}, {28'd259146097, 28'd70006387},
      {28'd258930101, 28'd70801107}, {28'd258711667, 28'd71595160}, {28'd258490799, 28'd72388539},
      {28'd258267497, 28'd73181237}, {28'd258041765, 28'd73973246}, {28'd257813604, 28'd74764559},
      {28'd257583016, 28'd75555168}, {28'd257350004, 28'd76345066}, {28'd257114569, 28'd77134246},
      {28'd256876715, 28'd77922699}, {28'd256636443, 28'd78710419}, {28'd256393755, 28'd79497398},
      {28'd256148653, 28'd80283629}, {28'd255901141, 28'd81069104}, {28'd255651220, 28'd81853816},
      {28'd255398893, 28'd82637758}, {28'd255144162, 28'd83420922}, {28'd254887030, 28'd84203301},
      {28'd254627498, 28'd84984887}, {28'd254365570, 28'd85765673}, {28'd254101247, 28'd86545652},
      {28'd253834533, 28'd87324816}, {28'd253565430, 28'd88103159}, {28'd253293940, 28'd88880672},
      {28'd253020066, 28'd89657348}, {28'd252743810, 28'd90433181}, {28'd252465175, 28'd91208162},
      {28'd252184165, 28'd91982285}, {28'd251900780, 28'd92755543}, {28'd251615025, 28'd93527927},
      {28'd251326901, 28'd94299431}, {28'd251036411, 28'd95070047}, {28'd250743559, 28'd95839768},
      {28'd250448347, 28'd96608588}, {28'd250150777, 28'd97376498}, {28'd249850853, 28'd98143491},
      {28'd249548577, 28'd98909561}, {28'd249243953, 28'd99674700}, {28'd248936982, 28'd100438900},
      {28'd248627668, 28'd101202156}, {28'd248316014, 28'd101964458}, {28'd248002023, 28'd102725801},
      {28'd247685698, 28'd103486177}, {28'd247367041, 28'd104245579}, {28'd247046056, 28'd105004000},
      {28'd246722745, 28'd105761432}, {28'd246397113, 28'd106517869}, {28'd246069161, 28'd107273304},
      {28'd245738893, 28'd108027729}, {28'd245406312, 28'd108781136}, {28'd245071421, 28'd109533520},
      {28'd244734224, 28'd110284873}, {28'd244394723, 28'd111035188}, {28'd244052922, 28'd111784458},
      {28'd243708823, 28'd112532676}, {28'd243362431, 28'd113279835}, {28'd243013748, 28'd114025927},
      {28'd242662778, 28'd114770946}, {28'd242309523, 28'd115514885}, {28'd241953988, 28'd116257736},
      {28'd241596176, 28'd116999493}, {28'd241236089, 28'd117740150}, {28'd240873733, 28'd118479697},
      {28'd240509108, 28'd119218130}, {28'd240142220, 28'd119955440}, {28'd239773072, 28'd120691622},
      {28'd239401667, 28'd121426667}, {28'd239028009, 28'd122160570}, {28'd238652100, 28'd122893322},
      {28'd238273946, 28'd123624918}, {28'd237893548, 28'd124355351}, {28'd237510912, 28'd125084613},
      {28'd237126040, 28'd125812697}, {28'd236738936, 28'd126539598}, {28'd236349604, 28'd127265307},
      {28'd235958047, 28'd127989818}, {28'd235564270, 28'd128713125}, {28'd235168275, 28'd129435220},
      {28'd234770066, 28'd130156097}, {28'd234369648, 28'd130875749}, {28'd233967024, 28'd131594169},
      {28'd233562198, 28'd132311350}, {28'd233155173, 28'd133027287}, {28'd232745954, 28'd133741970},
      {28'd232334544, 28'd134455396}, {28'd231920947, 28'd135167555}, {28'd231505167, 28'd135878442},
      {28'd231087209, 28'd136588051}, {28'd230667075, 28'd137296374}, {28'd230244770, 28'd138003404},
      {28'd229820298, 28'd138709136}, {28'd229393663, 28'd139413562}, {28'd228964868, 28'd140116675},
      {28'd228533919, 28'd140818470}, {28'd228100818, 28'd141518940}, {28'd227665571, 28'd142218077},
      {28'd227228181, 28'd142915876}, {28'd226788652, 28'd143612330}, {28'd226346988, 28'd144307431},
      {28'd225903194, 28'd145001175}, {28'd225457273, 28'd145693554}, {28'd225009231, 28'd146384561},
      {28'd224559070, 28'd147074191}, {28'd224106796, 28'd147762436}, {28'd223652413, 28'd148449291},
      {28'd223195924, 28'd149134748}, {28'd222737335, 28'd149818802}, {28'd222276649, 28'd150501445},
      {28'd221813871, 28'd151182672}, {28'd221349005, 28'd151862476}, {28'd220882056, 28'd152540851},
      {28'd220413028, 28'd153217789}, {28'd219941925, 28'd153893286}, {28'd219468752, 28'd154567334},
      {28'd218993513, 28'd155239927}, {28'd218516213, 28'd155911059}, {28'd218036856, 28'd156580724},
      {28'd217555447, 28'd157248914}, {28'd217071990, 28'd157915625}, {28'd216586490, 28'd158580849},
      {28'd216098952, 28'd159244581}, {28'd215609379, 28'd159906814}, {28'd215117778, 28'd160567542},
      {28'd214624151, 28'd161226758}, {28'd214128504, 28'd161884457}, {28'd213630842, 28'd162540632},
      {28'd213131169, 28'd163195277}, {28'd212629490, 28'd163848386}, {28'd212125809, 28'd164499953},
      {28'd211620132, 28'd165149972}, {28'd211112463, 28'd165798436}, {28'd210602807, 28'd166445340},
      {28'd210091169, 28'd167090677}, {28'd209577553, 28'd167734441}, {28'd209061965, 28'd168376627},
      {28'd208544409, 28'd169017227}, {28'd208024890, 28'd169656237}, {28'd207503413, 28'd170293650},
      {28'd206979983, 28'd170929460}, {28'd206454605, 28'd171563661}, {28'd205927283, 28'd172196248},
      {28'd205398023, 28'd172827213}, {28'd204866830, 28'd173456552}, {28'd204333709, 28'd174084258},
      {28'd203798664, 28'd174710326}, {28'd203261701, 28'd175334749}, {28'd202722825, 28'd175957522},
      {28'd202182041, 28'd176578639}, {28'd201639354, 28'd177198094}, {28'd201094769, 28'd177815881},
      {28'd200548291, 28'd178431994}, {28'd199999926, 28'd179046428}, {28'd199449678, 28'd179659176},
      {28'd198897553, 28'd180270234}, {28'd198343555, 28'd180879594}, {28'd197787691, 28'd181487253},
      {28'd197229965, 28'd182093203}, {28'd196670383, 28'd182697439}, {28'd196108950, 28'd183299955},
      {28'd195545670, 28'd183900746}, {28'd194980551, 28'd184499806}, {28'd194413595, 28'd185097130},
      {28'd193844811, 28'd185692711}, {28'd193274201, 28'd186286545}, {28'd192701772, 28'd186878625},
      {28'd192127530, 28'd187468946}, {28'd191551479, 28'd188057503}, {28'd190973625, 28'd188644290},
      {28'd190393974, 28'd189229301}, {28'd189812531, 28'd189812531}
   };

   // cos/sin of k * 2pi / 2048, k in 0..1023
   function automatic twiddle_type twiddle(input logic [9:0] k);
      logic [10:0]  m;
      logic         neg;
      logic         low;
      logic [8:0]   idx;
      logic [55:0]  entry;
      twiddle_type  tw;
      m   = {1'b0, k};
      neg = 1'b0;
      if (m > 11'd512) begin
         m   = 11'd1024 - m;
         neg = 1'b1;
      end
      low   = (m <= 11'd256);
      idx   = low ? m[8:0] : 9'(11'd512 - m);
      entry = QUARTER_ROM[idx];
      if (low) begin
         tw.c = $signed({1'b0, entry[55:28]});
         tw.s = $signed({1'b0, entry[27:0]});
      end else begin
         tw.c = $signed({1'b0, entry[27:0]});
         tw.s = $signed({1'b0, entry[55:28]});
      end
      if (neg) tw.c = -tw.c;
      return tw;
   endfunction

endpackage

`default_nettype wire

[design/fixed_point_fft_spectrum_magnitude_unit.sv]
// ----------------------------------------------------------------------------
// Fixed-point FFT spectrum magnitude unit
// Frame loader, in-place radix-2 DIF FFT and bin magnitude readout.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: cmd 0 loads the next sample of the frame, cmd 1 fetches the
//    next spectrum bin. A transaction on req is taken only while the unit idles
//    and no csr write is pending.
//  - rsp channel: one transaction per fetch, none per load. Without a finished
//    spectrum the fetch answers in the next cycle with all fields zero.
//  - csr channel: writes log2_points (used clamped to 1..MAX_LOG2_POINTS) and
//    restarts the frame. Write only while idle.
// Operation:
//  - a load is written straight into the frame memory. The load that completes
//    the frame starts the FFT: each butterfly runs 2 reads, the sum, 4 passes
//    through the one shared multiplier and a write back, over N/2*log2(N)
//    butterflies. The frame memory has a single read and write port.
//  - a fetch runs: read, two squares and the multiply by the bin on the
//    shared multiplier, a range check, then 16 steps of the square root
//    unit. A saturated bin skips the root.
// Reset: synchronous; frame count, bin pointer and ready flag clear, length
//  returns to 2048 points. Frame memory needs no clear.
// Stall: a result waits in the rsp register; req stays not ready until the
//  result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_fft_spectrum_magnitude_unit_assert.svh"

module fixed_point_fft_spectrum_magnitude_unit #(
   parameter int MAX_LOG2_POINTS = ffsm_pkg::MAX_LOG2_POINTS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  ffsm_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output ffsm_pkg::rsp_type            rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [ffsm_pkg::LOG2_W-1:0]   csr_data
);

   localparam int AW    = MAX_LOG2_POINTS;       // memory address width
   localparam int CW    = MAX_LOG2_POINTS + 1;   // frame count width
   localparam int DEPTH = 1 << MAX_LOG2_POINTS;
   localparam int LW    = ffsm_pkg::LOG2_W;

   typedef enum logic [16:0] {
      S_IDLE = 17'h00001,
      S_RDA  = 17'h00002,
      S_RDB  = 17'h00004,
      S_SUM  = 17'h00008,
      S_MUL0 = 17'h00010,
      S_MUL1 = 17'h00020,
      S_MUL2 = 17'h00040,
      S_MUL3 = 17'h00080,
      S_WRQ  = 17'h00100,
      S_FRD  = 17'h00200,
      S_FSQ0 = 17'h00400,
      S_FSQ1 = 17'h00800,
      S_FPW  = 17'h01000,
      S_FBIN = 17'h02000,
      S_FCHK = 17'h04000,
      S_SQRT = 17'h08000,
      S_FOUT = 17'h10000
   } state_type;

   // ---------------------------------------------------------------- state
   state_type          state_ff, state_in;
   logic [LW-1:0]      log2_ff, log2_in;
   logic [CW-1:0]      load_cnt_ff, load_cnt_in;
   logic [AW-1:0]      read_bin_ff, read_bin_in;
   logic               spec_ready_ff, spec_ready_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ffsm_pkg::rsp_type  rsp_ff, rsp_in;

   // FFT loop counters
   logic [LW-1:0]      lg_ff, lg_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [CW-1:0]      base_ff, base_in;

   // datapath registers
   logic [63:0]        a_ff, a_in;
   logic [31:0]        d0_ff, d0_in, d1_ff, d1_in;
   ffsm_pkg::twiddle_type tw_ff, tw_in;
   logic signed [62:0] prod_ff, prod_in;
   logic [31:0]        acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [AW-1:0]      bin_ff, bin_in;
   logic signed [19:0] im_ff, im_in;
   logic [39:0]        pw_ff, pw_in;
   logic               sat_ff, sat_in;
   logic [31:0]        sq_v_ff, sq_v_in, sq_res_ff, sq_res_in;
   logic [30:0]        sq_bit_ff, sq_bit_in;
   logic [15:0]        mag_ff, mag_in;

   // frame memory
   logic [63:0]        mem [DEPTH];
   logic [63:0]        rdata_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [63:0]        mem_wdata;

   // ------------------------------------------------------- derived values
   logic [LW-1:0]      n_eff;
   logic [CW-1:0]      total, half, h, next_base;
   logic [AW+9:0]      jk;
   logic [AW-1:0]      br_full, br_addr;
   logic               req_fire, csr_fire;
   logic signed [32:0] mul_a;
   logic signed [29:0] mul_b;
   logic signed [32:0] sum_re, sum_im;
   logic [32:0]        sq_try;
   logic [CW-1:0]      load_base;

   always_comb begin
      if (log2_ff == '0) n_eff = LW'(1);
      else if (log2_ff > LW'(MAX_LOG2_POINTS)) n_eff = LW'(MAX_LOG2_POINTS);
      else n_eff = log2_ff;
   end

   assign total     = CW'(1) << n_eff;
   assign half      = total >> 1;
   assign h         = CW'(1) << lg_ff;
   assign next_base = base_ff + (h << 1);
   assign jk        = {j_ff, 10'b0} >> lg_ff;

   always_comb begin
      for (int i = 0; i < AW; i++) br_full[i] = bin_ff[AW-1-i];
   end
   assign br_addr = br_full >> (LW'(AW) - n_eff);

   // truncating divide by 2^29 of a product, low 32 bits kept
   function automatic logic [31:0] rot_scale(input logic signed [62:0] p);
      logic signed [62:0] adj;
      adj = p + (p[62] ? 63'((64'd1 << ffsm_pkg::ROT_SHIFT) - 64'd1) : 63'd0);
      return adj[ffsm_pkg::ROT_SHIFT+31:ffsm_pkg::ROT_SHIFT];
   endfunction

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL0: begin mul_a = 33'(signed'(d0_ff)); mul_b = 30'(tw_ff.c); end
         S_MUL1: begin mul_a = 33'(signed'(d1_ff)); mul_b = 30'(tw_ff.s); end
         S_MUL2: begin mul_a = 33'(signed'(d0_ff)); mul_b = 30'(tw_ff.s); end
         S_MUL3: begin mul_a = 33'(signed'(d1_ff)); mul_b = 30'(tw_ff.c); end
         S_FSQ0: begin
            mul_a = 33'(signed'(rdata_ff[31:12]));
            mul_b = 30'(signed'(rdata_ff[31:12]));
         end
         S_FSQ1: begin mul_a = 33'(im_ff); mul_b = 30'(im_ff); end
         S_FBIN: begin
            mul_a = signed'({1'b0, pw_ff[31:0]});
            mul_b = signed'(30'(bin_ff));
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // butterfly sum: halve, truncating toward zero
   assign sum_re = 33'(signed'(a_ff[31:0]))  + 33'(signed'(rdata_ff[31:0]));
   assign sum_im = 33'(signed'(a_ff[63:32])) + 33'(signed'(rdata_ff[63:32]));

   assign sq_try    = 33'(sq_res_ff) + 33'(sq_bit_ff);
   assign load_base = (load_cnt_ff >= total) ? '0 : load_cnt_ff;

   // a pending csr write holds off req so both never land on the same edge
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in      = state_ff;
      log2_in       = log2_ff;
      load_cnt_in   = load_cnt_ff;
      read_bin_in   = read_bin_ff;
      spec_ready_in = spec_ready_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      lg_in         = lg_ff;
      j_in          = j_ff;
      base_in       = base_ff;
      a_in          = a_ff;
      d0_in         = d0_ff;
      d1_in         = d1_ff;
      tw_in         = tw_ff;
      prod_in       = mul_a * mul_b;
      acc_re_in     = acc_re_ff;
      acc_im_in     = acc_im_ff;
      bin_in        = bin_ff;
      im_in         = im_ff;
      pw_in         = pw_ff;
      sat_in        = sat_ff;
      sq_v_in       = sq_v_ff;
      sq_res_in     = sq_res_ff;
      sq_bit_in     = sq_bit_ff;
      mag_in        = mag_ff;
      rd_addr       = base_ff[AW-1:0];
      mem_we        = 1'b0;
      mem_waddr     = base_ff[AW-1:0];
      mem_wdata     = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               log2_in       = csr_data;
               load_cnt_in   = '0;
               read_bin_in   = AW'(1);
               spec_ready_in = 1'b0;
            end else if (req_fire && req_data.cmd == ffsm_pkg::CMD_LOAD) begin
               spec_ready_in = 1'b0;
               mem_we        = 1'b1;
               mem_waddr     = load_base[AW-1:0];
               mem_wdata     = {32'b0, {{4{req_data.sample[15]}}, req_data.sample,
                                        12'b0}};
               load_cnt_in   = load_base + CW'(1);
               if (load_cnt_in == total) begin
                  load_cnt_in = '0;
                  lg_in       = n_eff - LW'(1);
                  j_in        = '0;
                  base_in     = '0;
                  state_in    = S_RDA;
               end
            end else if (req_fire) begin
               if (!spec_ready_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end else begin
                  bin_in   = (read_bin_ff == '0 || CW'(read_bin_ff) > half) ?
                             AW'(1) : read_bin_ff;
                  state_in = S_FRD;
               end
            end
         end
         S_RDA: begin
            rd_addr  = base_ff[AW-1:0];
            state_in = S_RDB;
         end
         S_RDB: begin
            a_in     = rdata_ff;
            rd_addr  = AW'(base_ff + h);
            state_in = S_SUM;
         end
         S_SUM: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff[AW-1:0];
            mem_wdata = {32'((sum_im + 33'(sum_im[32])) >>> 1),
                         32'((sum_re + 33'(sum_re[32])) >>> 1)};
            d0_in     = a_ff[31:0]  - rdata_ff[31:0];
            d1_in     = a_ff[63:32] - rdata_ff[63:32];
            tw_in     = ffsm_pkg::twiddle(jk[9:0]);
            state_in  = S_MUL0;
         end
         S_MUL0: state_in = S_MUL1;
         S_MUL1: begin
            acc_re_in = rot_scale(prod_ff);
            state_in  = S_MUL2;
         end
         S_MUL2: begin
            acc_re_in = acc_re_ff - rot_scale(prod_ff);
            state_in  = S_MUL3;
         end
         S_MUL3: begin
            acc_im_in = rot_scale(prod_ff);
            state_in  = S_WRQ;
         end
         S_WRQ: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(base_ff + h);
            mem_wdata = {acc_im_ff + rot_scale(prod_ff), acc_re_ff};
            state_in  = S_RDA;
            if (next_base < total) begin
               base_in = next_base;
            end else if (CW'(j_ff) + CW'(1) < h) begin
               j_in    = j_ff + AW'(1);
               base_in = CW'(j_ff) + CW'(1);
            end else if (lg_ff != '0) begin
               lg_in   = lg_ff - LW'(1);
               j_in    = '0;
               base_in = '0;
            end else begin
               spec_ready_in = 1'b1;
               read_bin_in   = AW'(1);
               state_in      = S_IDLE;
            end
         end
         S_FRD: begin
            rd_addr  = br_addr;
            state_in = S_FSQ0;
         end
         S_FSQ0: begin
            im_in    = signed'(rdata_ff[63:44]);
            state_in = S_FSQ1;
         end
         S_FSQ1: begin
            pw_in    = 40'(prod_ff);
            state_in = S_FPW;
         end
         S_FPW: begin
            pw_in    = pw_ff + 40'(prod_ff);
            state_in = S_FBIN;
         end
         S_FBIN: begin
            sat_in   = (pw_ff[39:32] != '0);
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (sat_ff || prod_ff[62:32] != '0) begin
               mag_in   = ffsm_pkg::MAG_SAT;
               state_in = S_FOUT;
            end else begin
               sq_v_in   = prod_ff[31:0];
               sq_res_in = '0;
               sq_bit_in = 31'h4000_0000;
               state_in  = S_SQRT;
            end
         end
         S_SQRT: begin
            if (33'(sq_v_ff) >= sq_try) begin
               sq_v_in   = 32'(33'(sq_v_ff) - sq_try);
               sq_res_in = (sq_res_ff >> 1) + 32'(sq_bit_ff);
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff == 31'd1) begin
               mag_in   = sq_res_in[15:0];
               state_in = S_FOUT;
            end
         end
         S_FOUT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.bin_index  = 11'(bin_ff);
            rsp_in.magnitude  = mag_ff;
            rsp_in.last       = (CW'(bin_ff) == half);
            rsp_in.ready_res  = 1'b1;
            read_bin_in       = (CW'(bin_ff) == half) ? AW'(1) : bin_ff + AW'(1);
            state_in          = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         log2_ff       <= LW'(ffsm_pkg::LOG2_RESET);
         load_cnt_ff   <= '0;
         read_bin_ff   <= AW'(1);
         spec_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         log2_ff       <= log2_in;
         load_cnt_ff   <= load_cnt_in;
         read_bin_ff   <= read_bin_in;
         spec_ready_ff <= spec_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      lg_ff     <= lg_in;
      j_ff      <= j_in;
      base_ff   <= base_in;
      a_ff      <= a_in;
      d0_ff     <= d0_in;
      d1_ff     <= d1_in;
      tw_ff     <= tw_in;
      prod_ff   <= prod_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      bin_ff    <= bin_in;
      im_ff     <= im_in;
      pw_ff     <= pw_in;
      sat_ff    <= sat_in;
      sq_v_ff   <= sq_v_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      mag_ff    <= mag_in;
   end

   // frame / spectrum memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[rd_addr];
   end

   // ----------------------------------------------------------- assertions
   `FFSM_ASSERT(a_ready_only_idle, clock, reset, req_ready |-> state_ff == S_IDLE)
   `FFSM_ASSERT(a_last_has_spectrum, clock, reset, (rsp_valid && rsp_data.last) |-> rsp_data.ready_res)
   `FFSM_NEVER(a_valid_bin_nonzero, clock, reset, rsp_valid && rsp_data.ready_res && rsp_data.bin_index == '0)
   `FFSM_ASSERT(a_fft_done_sets_ready, clock, reset, (state_ff == S_WRQ && state_in == S_IDLE) |=> spec_ready_ff)

endmodule

`default_nettype wire

[sim/fixed_point_fft_spectrum_magnitude_unit_tb.sv]
// ----------------------------------------------------------------------------
// Spectrum magnitude unit testbench
// Loads frames of samples, fetches bins and checks each magnitude against an
// in-bench fixed-point FFT. Covers frame lengths up to 128 points, length
// clamping, fetches without a spectrum, bin wrap, saturation, and receiver
// stalls that back up the request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_fft_spectrum_magnitude_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  MEM_WORDS   = 1 << ffsm_pkg::MAX_LOG2_POINTS_DEF;
   localparam int  CYCLE_LIMIT = 2_000_000;
   localparam int  HOLD_CYCLES = 400;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ffsm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ffsm_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [ffsm_pkg::LOG2_W-1:0] csr_data;

   fixed_point_fft_spectrum_magnitude_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // ------------------------------------------------------------------------
   // Spectrum predictor state: length register, frame counter, bin pointer,
   // ready flag and the frame/spectrum buffer (re, im as 32-bit words).
   // ------------------------------------------------------------------------
   logic [ffsm_pkg::LOG2_W-1:0] pred_log2;
   int unsigned       pred_load_cnt;
   int unsigned       pred_bin;
   bit                pred_ready;
   logic signed [31:0] buf_re [MEM_WORDS];
   logic signed [31:0] buf_im [MEM_WORDS];

   ffsm_pkg::rsp_type expected_bins[$];
   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned items_sent;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic        hold_req;
   int unsigned hold_left;

   function automatic int unsigned frame_log2();
      if (pred_log2 < 1) return 1;
      if (pred_log2 > ffsm_pkg::MAX_LOG2_POINTS_DEF) return ffsm_pkg::MAX_LOG2_POINTS_DEF;
      return pred_log2;
   endfunction

   function automatic longint to_s32(longint v);
      logic signed [31:0] t;
      t = v[31:0];
      return t;
   endfunction

   // cos/sin of k/2048 of a turn, k in 0..1023, built from the quarter ROM
   function automatic void rotation_for(int unsigned k, output longint c,
                                        output longint s);
      int unsigned m;
      bit          neg;
      logic [55:0] entry;
      m   = k & 1023;
      neg = 0;
      if (m > 512) begin
         m   = 1024 - m;
         neg = 1;
      end
      if (m <= 256) begin
         entry = ffsm_pkg::QUARTER_ROM[m];
         c = longint'(entry[55:28]);
         s = longint'(entry[27:0]);
      end else begin
         entry = ffsm_pkg::QUARTER_ROM[512 - m];
         c = longint'(entry[27:0]);
         s = longint'(entry[55:28]);
      end
      if (neg) c = -c;
   endfunction

   // in-place radix-2 DIF pass over the loaded frame
   function automatic void transform_frame(int unsigned n);
      int unsigned total, lg, h, p, q;
      longint c, s, a0, a1, b0, b1, d0, d1, sc;
      total = 1 << n;
      sc    = 64'sd1 << ffsm_pkg::ROT_SHIFT;
      for (int unsigned st = 0; st < n; st++) begin
         lg = n - 1 - st;
         h  = 1 << lg;
         for (int unsigned j = 0; j < h; j++) begin
            rotation_for((j << 10) >> lg, c, s);
            for (int unsigned base = j; base < total; base += 2 * h) begin
               p  = base;
               q  = base + h;
               a0 = buf_re[p];
               a1 = buf_im[p];
               b0 = buf_re[q];
               b1 = buf_im[q];
               d0 = to_s32(a0 - b0);
               d1 = to_s32(a1 - b1);
               buf_re[p] = 32'((a0 + b0) / 2);
               buf_im[p] = 32'((a1 + b1) / 2);
               buf_re[q] = 32'(to_s32((d0 * c) / sc - (d1 * s) / sc));
               buf_im[q] = 32'(to_s32((d0 * s) / sc + (d1 * c) / sc));
            end
         end
      end
   endfunction

   function automatic int unsigned floor_root(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt  = 64'd1 << 30;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return 32'(res);
   endfunction

   function automatic int unsigned reverse_bits(int unsigned v, int unsigned n);
      int unsigned r;
      r = 0;
      for (int unsigned i = 0; i < n; i++) r = (r << 1) | ((v >> i) & 1);
      return r;
   endfunction

   // advance the predictor by one accepted request
   function automatic void predict_request(ffsm_pkg::req_type rq);
      int unsigned       n, total, half, bin, addr;
      longint            re, im;
      longint unsigned   pw, prod;
      ffsm_pkg::rsp_type rs;
      n     = frame_log2();
      total = 1 << n;
      half  = total >> 1;
      if (rq.cmd == ffsm_pkg::CMD_LOAD) begin
         pred_ready = 0;
         if (pred_load_cnt >= total) pred_load_cnt = 0;
         buf_re[pred_load_cnt] = 32'(longint'(rq.sample) << ffsm_pkg::SAMPLE_SHIFT);
         buf_im[pred_load_cnt] = '0;
         pred_load_cnt++;
         if (pred_load_cnt == total) begin
            transform_frame(n);
            pred_load_cnt = 0;
            pred_bin      = 1;
            pred_ready    = 1;
         end
         return;
      end
      rs = '0;
      if (pred_ready) begin
         bin  = (pred_bin < 1 || pred_bin > half) ? 1 : pred_bin;
         addr = reverse_bits(bin, n);
         re   = longint'(buf_re[addr]) >>> ffsm_pkg::SAMPLE_SHIFT;
         im   = longint'(buf_im[addr]) >>> ffsm_pkg::SAMPLE_SHIFT;
         pw   = longint'(re * re) + longint'(im * im);
         prod = pw * bin;
         rs.bin_index = 11'(bin);
         rs.magnitude = (prod >= (64'd1 << 32)) ? ffsm_pkg::MAG_SAT :
                        16'(floor_root(prod));
         rs.last      = (bin == half);
         rs.ready_res = 1'b1;
         pred_bin     = (bin == half) ? 1 : bin + 1;
      end
      expected_bins.push_back(rs);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: idle cycles at the set rate, valid held until the
   // transaction completes
   // ------------------------------------------------------------------------
   task automatic send_request(logic cmd, logic signed [15:0] smp);
      ffsm_pkg::req_type rq;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      rq.cmd    = cmd;
      rq.sample = smp;
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      predict_request(rq);
      items_sent++;
   endtask

   task automatic load_sample(logic signed [15:0] smp);
      send_request(ffsm_pkg::CMD_LOAD, smp);
   endtask

   task automatic fetch_bin();
      send_request(ffsm_pkg::CMD_FETCH, 16'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
   endtask

   // Length write only while idle: drain fetches, then let any FFT that a
   // final load kicked off run out.
   task automatic write_length(logic [ffsm_pkg::LOG2_W-1:0] value);
      int unsigned n;
      wait_drained();
      n = frame_log2();
      repeat (8 * (1 << (n - 1)) * n + 64) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      pred_log2     = value;
      pred_load_cnt = 0;
      pred_bin      = 1;
      pred_ready    = 0;
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(15)) - 16'sd8;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------------

   // smallest frames, fetch before any spectrum, wrap, load over a spectrum,
   // length zero clamped up to one
   task automatic test_directed();
      write_length(4'd1);
      fetch_bin();                 // no spectrum yet
      load_sample(16'sh7FFF);
      load_sample(16'sh8000);
      fetch_bin();
      fetch_bin();                 // wraps back to bin 1
      write_length(4'd2);
      load_sample(16'sh8000);
      load_sample(16'sh7FFF);
      load_sample(16'sh0000);
      load_sample(16'shFFFF);
      fetch_bin();
      fetch_bin();
      fetch_bin();
      load_sample(16'sh0001);      // drops the spectrum
      fetch_bin();
      write_length(4'd0);
      load_sample(16'sh1234);
      load_sample(16'shEDCB);
      fetch_bin();
   endtask

   // full-scale tone at Nyquist: the top bin saturates
   task automatic test_saturation();
      write_length(4'd4);
      for (int i = 0; i < 16; i++) load_sample(i[0] ? 16'sh8000 : 16'sh7FFF);
      repeat (8) fetch_bin();
   endtask

   // mostly whole frames with random content, plus stray fetches and
   // fetches into half-loaded frames; frame size kept within the quota left
   task automatic test_random_frames(int unsigned quota);
      int unsigned start, n, total, frames, left;
      start = items_sent;
      while (items_sent - start < quota) begin
         left = quota - (items_sent - start);
         n    = $urandom_range(1, 6);
         while (n > 1 && (1 << n) > left) n--;
         write_length(4'(n));
         total  = 1 << n;
         frames = (n >= 5) ? 1 : $urandom_range(1, 3);
         repeat (frames) begin
            if ($urandom_range(4) == 0) fetch_bin();
            for (int unsigned i = 0; i < total; i++) begin
               load_sample(pick_sample());
               if (i + 1 < total && $urandom_range(99) < 3) fetch_bin();
            end
            repeat ($urandom_range(1, total / 2 + 2)) fetch_bin();
         end
      end
   endtask

   // receiver holds off while fetches keep coming, so the request side stalls
   task automatic test_backpressure();
      write_length(4'd3);
      for (int i = 0; i < 8; i++) load_sample(pick_sample());
      wait_drained();
      repeat (8 * 4 * 3 + 64) @(posedge clock);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (10) fetch_bin();
   endtask

   // 15 clamps to the maximum (partial frame only), then a 128-point frame,
   // then the maximum written as is
   task automatic test_clamp_and_long_frame();
      write_length(4'd15);
      for (int i = 0; i < 20; i++) load_sample(pick_sample());
      fetch_bin();                 // frame not complete, no spectrum
      write_length(4'd7);
      for (int i = 0; i < 128; i++) load_sample(pick_sample());
      repeat (4) fetch_bin();
      write_length(4'd11);
      fetch_bin();
      write_length(4'd5);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random ready, or a long hold-off counted here
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker: every rsp transaction against the oldest expectation
   always @(posedge clock) begin
      ffsm_pkg::rsp_type exp_bin;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: bin %0d mag %0d last %0b ready %0b",
                        rsp_data.bin_index, rsp_data.magnitude, rsp_data.last,
                        rsp_data.ready_res);
         end else begin
            exp_bin = expected_bins.pop_front();
            if (rsp_data.bin_index !== exp_bin.bin_index ||
                rsp_data.magnitude !== exp_bin.magnitude ||
                rsp_data.last      !== exp_bin.last ||
                rsp_data.ready_res !== exp_bin.ready_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"bin mismatch: exp bin %0d mag %0d last %0b ready %0b,",
                            " got bin %0d mag %0d last %0b ready %0b"},
                           exp_bin.bin_index, exp_bin.magnitude, exp_bin.last,
                           exp_bin.ready_res, rsp_data.bin_index,
                           rsp_data.magnitude, rsp_data.last, rsp_data.ready_res);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      rsp_ready     = 1'b0;
      hold_req      = 1'b0;
      hold_left     = 0;
      cycle_count   = 0;
      mismatches    = 0;
      items_sent    = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pred_log2     = 4'(ffsm_pkg::LOG2_RESET);
      pred_load_cnt = 0;
      pred_bin      = 1;
      pred_ready    = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_saturation();

      send_idle_pct = 28;
      recv_idle_pct = 73;
      test_random_frames(110);
      test_backpressure();

      send_idle_pct = 73;
      recv_idle_pct = 28;
      test_random_frames(110);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(110);
      test_clamp_and_long_frame();

      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_bins.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/ffsm_pkg.sv
design/fixed_point_fft_spectrum_magnitude_unit.sv
sim/fixed_point_fft_spectrum_magnitude_unit_tb.sv
